/* src/cmvm_pkg.sv */
// ----------------------------------------------------------------------------
// cmvm_pkg
// Shared types and constants for the complex matrix-vector MAC block.
// ----------------------------------------------------------------------------
`default_nettype none

package cmvm_pkg;

   localparam int SAMPLE_WIDTH_DEF = 16;
   localparam int ACC_WIDTH_DEF    = 48;
   localparam int QUEUE_DEPTH      = 4;

   localparam logic REG_CONJUGATE = 1'b0;
   localparam logic REG_COMBINE   = 1'b1;

   typedef enum logic [1:0] {
      COMBINE_ZERO = 2'd0,
      COMBINE_ADD  = 2'd1,
      COMBINE_SUB  = 2'd2
   } combine_mode_type;

   typedef struct packed {
      logic conjugate;
      logic use_start;
      logic subtract;
   } cfg_type;

   typedef struct packed {
      logic last;
      logic use_start;
      logic subtract;
   } item_ctl_type;

   typedef struct packed {
      logic pop;
      logic pop_last;
   } back_stat_type;

endpackage

`default_nettype wire

/* src/cmvm_front.sv */
// ----------------------------------------------------------------------------
// cmvm_front
// Input pipeline: captures operands, applies the conjugate, forms the four
// partial products and combines them into the complex product.
// ----------------------------------------------------------------------------
`default_nettype none

module cmvm_front
   import cmvm_pkg::*;
#(
   parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
   parameter int ACC_WIDTH    = ACC_WIDTH_DEF,
   localparam int PW          = 2 * SAMPLE_WIDTH + 1
) (
   input  logic                    clock,
   input  logic                    reset,
   input  cfg_type                 cfg,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  logic [SAMPLE_WIDTH-1:0] in_mat_re,
   input  logic [SAMPLE_WIDTH-1:0] in_mat_im,
   input  logic [SAMPLE_WIDTH-1:0] in_vec_re,
   input  logic [SAMPLE_WIDTH-1:0] in_vec_im,
   input  logic [ACC_WIDTH-1:0]    in_start_re,
   input  logic [ACC_WIDTH-1:0]    in_start_im,
   input  logic                    in_last,
   output logic                    out_valid,
   input  logic                    out_ready,
   output logic [PW-1:0]           out_prod_re,
   output logic [PW-1:0]           out_prod_im,
   output logic [ACC_WIDTH-1:0]    out_start_re,
   output logic [ACC_WIDTH-1:0]    out_start_im,
   output item_ctl_type            out_ctl
);

   logic en1, en2, en3;
   logic v1_ff, v2_ff, v3_ff;
   logic v1_in, v2_in, v3_in;

   logic signed [SAMPLE_WIDTH-1:0] ar_ff, xr_ff, xi_ff;
   logic signed [SAMPLE_WIDTH:0]   ai_ff, ai_in;
   logic [SAMPLE_WIDTH:0]          mat_im_x;
   logic [ACC_WIDTH-1:0]           st_re1_ff, st_im1_ff, st_re2_ff, st_im2_ff;
   logic [ACC_WIDTH-1:0]           st_re3_ff, st_im3_ff;
   item_ctl_type                   ctl1_ff, ctl2_ff, ctl3_ff;

   logic signed [PW-1:0] p_rr_ff, p_ii_ff, p_ri_ff, p_ir_ff;
   logic signed [PW-1:0] p_rr_in, p_ii_in, p_ri_in, p_ir_in;
   logic signed [PW-1:0] pr_ff, pi_ff, pr_in, pi_in;

   assign en3 = !v3_ff || out_ready;
   assign en2 = !v2_ff || en3;
   assign en1 = !v1_ff || en2;
   assign in_ready = en1;

   assign v1_in = en1 ? in_valid : v1_ff;
   assign v2_in = en2 ? v1_ff : v2_ff;
   assign v3_in = en3 ? v2_ff : v3_ff;

   always_comb begin
      mat_im_x = {in_mat_im[SAMPLE_WIDTH-1], in_mat_im};
      ai_in    = cfg.conjugate ? $signed((SAMPLE_WIDTH+1)'(0) - mat_im_x)
                               : $signed(mat_im_x);
      p_rr_in  = ar_ff * xr_ff;
      p_ii_in  = ai_ff * xi_ff;
      p_ri_in  = ar_ff * xi_ff;
      p_ir_in  = ai_ff * xr_ff;
      pr_in    = p_rr_ff - p_ii_ff;
      pi_in    = p_ri_ff + p_ir_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en1 && in_valid) begin
         ar_ff     <= $signed(in_mat_re);
         ai_ff     <= ai_in;
         xr_ff     <= $signed(in_vec_re);
         xi_ff     <= $signed(in_vec_im);
         st_re1_ff <= in_start_re;
         st_im1_ff <= in_start_im;
         ctl1_ff   <= '{last: in_last, use_start: cfg.use_start, subtract: cfg.subtract};
      end
      if (en2 && v1_ff) begin
         p_rr_ff   <= p_rr_in;
         p_ii_ff   <= p_ii_in;
         p_ri_ff   <= p_ri_in;
         p_ir_ff   <= p_ir_in;
         st_re2_ff <= st_re1_ff;
         st_im2_ff <= st_im1_ff;
         ctl2_ff   <= ctl1_ff;
      end
      if (en3 && v2_ff) begin
         pr_ff     <= pr_in;
         pi_ff     <= pi_in;
         st_re3_ff <= st_re2_ff;
         st_im3_ff <= st_im2_ff;
         ctl3_ff   <= ctl2_ff;
      end
   end

   assign out_valid    = v3_ff;
   assign out_prod_re  = pr_ff;
   assign out_prod_im  = pi_ff;
   assign out_start_re = st_re3_ff;
   assign out_start_im = st_im3_ff;
   assign out_ctl      = ctl3_ff;

endmodule

`default_nettype wire

/* src/cmvm_queue.sv */
// ----------------------------------------------------------------------------
// cmvm_queue
// Short register queue between the product pipeline and the accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

module cmvm_queue
   import cmvm_pkg::*;
#(
   parameter int WIDTH = 8,
   parameter int DEPTH = QUEUE_DEPTH,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  logic [WIDTH-1:0] in_data,
   output logic             out_valid,
   input  logic             out_ready,
   output logic [WIDTH-1:0] out_data
);

   logic [WIDTH-1:0] entry_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [AW:0]      count_ff, count_in;
   logic             push, pop;

   assign in_ready  = count_ff != (AW+1)'(DEPTH);
   assign out_valid = count_ff != '0;
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;
   assign out_data  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= in_data;
      end
   end

endmodule

`default_nettype wire

/* src/cmvm_back.sv */
// ----------------------------------------------------------------------------
// cmvm_back
// Saturating complex accumulator with the result output register.
// ----------------------------------------------------------------------------
`default_nettype none

module cmvm_back
   import cmvm_pkg::*;
#(
   parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
   parameter int ACC_WIDTH    = ACC_WIDTH_DEF,
   localparam int PW          = 2 * SAMPLE_WIDTH + 1,
   localparam int SUM_W       = ((ACC_WIDTH > PW) ? ACC_WIDTH : PW) + 1
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  logic [PW-1:0]        in_prod_re,
   input  logic [PW-1:0]        in_prod_im,
   input  logic [ACC_WIDTH-1:0] in_start_re,
   input  logic [ACC_WIDTH-1:0] in_start_im,
   input  item_ctl_type         in_ctl,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [ACC_WIDTH-1:0] rsp_sum_re,
   output logic [ACC_WIDTH-1:0] rsp_sum_im,
   output logic                 rsp_saturated,
   output back_stat_type        stat
);

   logic                 first_ff, first_in;
   logic                 sat_ff, sat_in;
   logic [ACC_WIDTH-1:0] acc_re_ff, acc_re_in, acc_im_ff, acc_im_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [ACC_WIDTH-1:0] sum_re_ff, sum_im_ff;
   logic                 sum_sat_ff;
   logic [ACC_WIDTH-1:0] base_re, base_im;
   logic [ACC_WIDTH:0]   step_re, step_im;
   logic                 pop;

   function automatic logic [ACC_WIDTH:0] acc_step(input logic [ACC_WIDTH-1:0] base,
                                                   input logic [PW-1:0] d,
                                                   input logic sub);
      logic [SUM_W-1:0]         a_x, d_x, s;
      logic [SUM_W-ACC_WIDTH:0] top;
      logic                     ovf;
      logic [ACC_WIDTH-1:0]     value;
      a_x   = {{(SUM_W-ACC_WIDTH){base[ACC_WIDTH-1]}}, base};
      d_x   = {{(SUM_W-PW){d[PW-1]}}, d};
      s     = sub ? a_x - d_x : a_x + d_x;
      top   = s[SUM_W-1:ACC_WIDTH-1];
      ovf   = !((&top) || !(|top));
      value = s[ACC_WIDTH-1:0];
      if (ovf) begin
         value = s[SUM_W-1] ? {1'b1, {(ACC_WIDTH-1){1'b0}}}
                            : {1'b0, {(ACC_WIDTH-1){1'b1}}};
      end
      return {ovf, value};
   endfunction

   assign in_ready = !in_ctl.last || !rsp_valid_ff || rsp_ready;
   assign pop      = in_valid && in_ready;

   always_comb begin
      base_re = acc_re_ff;
      base_im = acc_im_ff;
      if (first_ff) begin
         base_re = in_ctl.use_start ? in_start_re : '0;
         base_im = in_ctl.use_start ? in_start_im : '0;
      end
      step_re   = acc_step(base_re, in_prod_re, in_ctl.subtract);
      step_im   = acc_step(base_im, in_prod_im, in_ctl.subtract);
      acc_re_in = acc_re_ff;
      acc_im_in = acc_im_ff;
      sat_in    = sat_ff;
      first_in  = first_ff;
      if (pop) begin
         acc_re_in = step_re[ACC_WIDTH-1:0];
         acc_im_in = step_im[ACC_WIDTH-1:0];
         sat_in    = (sat_ff && !first_ff) || step_re[ACC_WIDTH] || step_im[ACC_WIDTH];
         first_in  = in_ctl.last;
      end
      if (pop && in_ctl.last) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && !rsp_ready;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_ff     <= 1'b1;
         sat_ff       <= 1'b0;
         acc_re_ff    <= '0;
         acc_im_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         first_ff     <= first_in;
         sat_ff       <= sat_in;
         acc_re_ff    <= acc_re_in;
         acc_im_ff    <= acc_im_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop && in_ctl.last) begin
         sum_re_ff  <= acc_re_in;
         sum_im_ff  <= acc_im_in;
         sum_sat_ff <= sat_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_sum_re    = sum_re_ff;
   assign rsp_sum_im    = sum_im_ff;
   assign rsp_saturated = sum_sat_ff;
   assign stat          = '{pop: pop, pop_last: pop && in_ctl.last};

endmodule

`default_nettype wire

/* src/complex_matrix_vector_mac.sv */
// ----------------------------------------------------------------------------
// complex_matrix_vector_mac
// Streaming complex multiply-accumulate for matrix-vector products.
//
// Each req transaction carries one matrix element and one vector element in
// Q1.15, the start value of the run and tlast on the final term of a run.
// The product, conjugated on the matrix side when enabled, is added to or
// subtracted from a saturating 48-bit complex accumulator in Q18.30.
// The rsp transaction carries the finished sum and a saturation flag.
// One term is accepted every cycle while req_tready is high; the rate is
// set by the accumulator adder loop. When the receiver stalls, the result
// waits in the output register while terms keep flowing through the
// product pipeline and the queue; req_tready drops only once the queue
// and the three product pipeline stages are full. Reset empties the
// pipeline and queue, starts a new run and clears the configuration.
// The user writes configuration through csr_ only while no run is in
// flight; the block itself does not enforce this.
// ----------------------------------------------------------------------------
`default_nettype none

module complex_matrix_vector_mac
   import cmvm_pkg::*;
#(
   parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
   parameter int ACC_WIDTH    = ACC_WIDTH_DEF,
   localparam int REQ_DATA_W  = ((4 * SAMPLE_WIDTH + 2 * ACC_WIDTH) + 7) / 8 * 8,
   localparam int RSP_DATA_W  = ((2 * ACC_WIDTH) + 7) / 8 * 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // mat_re, mat_im, vec_re, vec_im, start_re, start_im
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  req_tlast,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // sum_re, sum_im
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // saturated
   output logic                  rsp_tuser,
   input  logic                  csr_we,
   input  logic                  csr_addr,
   input  logic [1:0]            csr_wdata
);

   localparam int SW  = SAMPLE_WIDTH;
   localparam int PW  = 2 * SAMPLE_WIDTH + 1;
   localparam int QW  = 2 * PW + 2 * ACC_WIDTH + $bits(item_ctl_type);

   logic          conj_ff;
   logic [1:0]    mode_ff;
   cfg_type       cfg;

   logic                 f_valid, f_ready;
   logic [PW-1:0]        f_prod_re, f_prod_im;
   logic [ACC_WIDTH-1:0] f_start_re, f_start_im;
   item_ctl_type         f_ctl;

   logic                 q_valid, q_ready;
   logic [QW-1:0]        q_in_data, q_out_data;
   logic [PW-1:0]        q_prod_re, q_prod_im;
   logic [ACC_WIDTH-1:0] q_start_re, q_start_im;
   item_ctl_type         q_ctl;

   logic [ACC_WIDTH-1:0] sum_re, sum_im;
   back_stat_type        stat;

   always_ff @(posedge clock) begin
      if (reset) begin
         conj_ff <= 1'b0;
         mode_ff <= COMBINE_ZERO;
      end else if (csr_we) begin
         case (csr_addr)
            REG_CONJUGATE: conj_ff <= csr_wdata[0];
            REG_COMBINE:   mode_ff <= csr_wdata;
            default:       conj_ff <= conj_ff;
         endcase
      end
   end

   always_comb begin
      cfg.conjugate = conj_ff;
      case (combine_mode_type'(mode_ff))
         COMBINE_ADD: begin
            cfg.use_start = 1'b1;
            cfg.subtract  = 1'b0;
         end
         COMBINE_SUB: begin
            cfg.use_start = 1'b1;
            cfg.subtract  = 1'b1;
         end
         default: begin
            cfg.use_start = 1'b0;
            cfg.subtract  = 1'b0;
         end
      endcase
   end

   cmvm_front #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH),
      .ACC_WIDTH    (ACC_WIDTH)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg),
      .in_valid     (req_tvalid),
      .in_ready     (req_tready),
      .in_mat_re    (req_tdata[SW-1:0]),
      .in_mat_im    (req_tdata[2*SW-1:SW]),
      .in_vec_re    (req_tdata[3*SW-1:2*SW]),
      .in_vec_im    (req_tdata[4*SW-1:3*SW]),
      .in_start_re  (req_tdata[4*SW+ACC_WIDTH-1:4*SW]),
      .in_start_im  (req_tdata[4*SW+2*ACC_WIDTH-1:4*SW+ACC_WIDTH]),
      .in_last      (req_tlast),
      .out_valid    (f_valid),
      .out_ready    (f_ready),
      .out_prod_re  (f_prod_re),
      .out_prod_im  (f_prod_im),
      .out_start_re (f_start_re),
      .out_start_im (f_start_im),
      .out_ctl      (f_ctl)
   );

   assign q_in_data = {f_ctl, f_start_im, f_start_re, f_prod_im, f_prod_re};

   cmvm_queue #(
      .WIDTH     (QW),
      .DEPTH     (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (f_valid),
      .in_ready  (f_ready),
      .in_data   (q_in_data),
      .out_valid (q_valid),
      .out_ready (q_ready),
      .out_data  (q_out_data)
   );

   assign {q_ctl, q_start_im, q_start_re, q_prod_im, q_prod_re} = q_out_data;

   cmvm_back #(
      .SAMPLE_WIDTH  (SAMPLE_WIDTH),
      .ACC_WIDTH     (ACC_WIDTH)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (q_valid),
      .in_ready      (q_ready),
      .in_prod_re    (q_prod_re),
      .in_prod_im    (q_prod_im),
      .in_start_re   (q_start_re),
      .in_start_im   (q_start_im),
      .in_ctl        (q_ctl),
      .rsp_valid     (rsp_tvalid),
      .rsp_ready     (rsp_tready),
      .rsp_sum_re    (sum_re),
      .rsp_sum_im    (sum_im),
      .rsp_saturated (rsp_tuser),
      .stat          (stat)
   );

   assign rsp_tdata = RSP_DATA_W'({sum_im, sum_re});

   a_result_follows_last: assert property (@(posedge clock) disable iff (reset)
      stat.pop_last |=> rsp_tvalid)
      else $error("finished run did not raise rsp_tvalid");

   a_result_has_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(stat.pop_last))
      else $error("rsp_tvalid rose without a finished run");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |-> !stat.pop_last)
      else $error("waiting result overwritten");

endmodule

`default_nettype wire

/* test/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench for the complex matrix-vector MAC block.
//
// A driver streams matrix and vector terms on req from a queue of pending
// transactions, and a monitor predicts each finished sum with its own
// saturating complex accumulator and compares it with the rsp transaction.
// Directed runs cover the sample extremes, conjugation, every combine mode
// and saturation, and random runs follow under each combine mode.
// ----------------------------------------------------------------------------

module tb_top;
   import cmvm_pkg::*;

   localparam int SAMPLE_W = SAMPLE_WIDTH_DEF;
   localparam int ACC_W    = ACC_WIDTH_DEF;
   localparam int REQ_W    = ((4 * SAMPLE_W + 2 * ACC_W) + 7) / 8 * 8;
   localparam int RSP_W    = ((2 * ACC_W) + 7) / 8 * 8;
   localparam int WATCHDOG_LIMIT = 5000;

   localparam logic [1:0] COMBINE_UNUSED = 2'd3;

   localparam longint ACC_HI = (64'sd1 <<< (ACC_W - 1)) - 1;
   localparam longint ACC_LO = -ACC_HI - 1;
   localparam logic [ACC_W-1:0] START_MAX = ACC_HI[ACC_W-1:0];
   localparam logic [ACC_W-1:0] START_MIN = ACC_LO[ACC_W-1:0];
   localparam logic signed [SAMPLE_W-1:0] S_MAX = 16'sh7fff;
   localparam logic signed [SAMPLE_W-1:0] S_MIN = 16'sh8000;

   typedef struct {
      logic signed [SAMPLE_W-1:0] mat_re;
      logic signed [SAMPLE_W-1:0] mat_im;
      logic signed [SAMPLE_W-1:0] vec_re;
      logic signed [SAMPLE_W-1:0] vec_im;
      logic signed [ACC_W-1:0]    start_re;
      logic signed [ACC_W-1:0]    start_im;
      logic                       last;
   } term_type;

   typedef struct {
      logic [ACC_W-1:0] re;
      logic [ACC_W-1:0] im;
      logic             saturated;
   } sum_type;

   logic             clock      = 1'b0;
   logic             reset      = 1'b1;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   logic [REQ_W-1:0] req_tdata  = '0;
   logic             req_tlast  = 1'b0;
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   logic [RSP_W-1:0] rsp_tdata;
   logic             rsp_tuser;
   logic             csr_we     = 1'b0;
   logic             csr_addr   = 1'b0;
   logic [1:0]       csr_wdata  = 2'd0;

   term_type term_queue[$];
   sum_type  sum_queue[$];
   term_type req_item;
   logic   req_taken   = 1'b0;
   bit     steady      = 1'b0;
   int     terms_queued = 0;
   int     terms_sent   = 0;
   int     fail_count   = 0;
   int     idle_cycles  = 0;

   logic       conj_cfg = 1'b0;
   logic [1:0] mode_cfg = COMBINE_ZERO;
   longint     run_re   = 0;
   longint     run_im   = 0;
   bit         run_open = 1'b0;
   bit         run_saturated = 1'b0;

   logic [1:0] combine_seq [6] = '{COMBINE_ZERO, COMBINE_ADD, COMBINE_SUB,
                                   COMBINE_UNUSED, COMBINE_SUB, COMBINE_ADD};

   complex_matrix_vector_mac i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   function automatic longint saturate(input longint value);
      if (value > ACC_HI) begin
         run_saturated = 1'b1;
         return ACC_HI;
      end
      if (value < ACC_LO) begin
         run_saturated = 1'b1;
         return ACC_LO;
      end
      return value;
   endfunction

   function automatic void accumulate_term(input term_type t);
      longint  ar, ai, xr, xi, pr, pi;
      sum_type s;
      ar = t.mat_re;
      ai = t.mat_im;
      xr = t.vec_re;
      xi = t.vec_im;
      if (conj_cfg)
         ai = -ai;
      if (!run_open) begin
         run_saturated = 1'b0;
         if (mode_cfg == COMBINE_ADD || mode_cfg == COMBINE_SUB) begin
            run_re = t.start_re;
            run_im = t.start_im;
         end else begin
            run_re = 0;
            run_im = 0;
         end
      end
      pr = ar * xr - ai * xi;
      pi = ar * xi + ai * xr;
      if (mode_cfg == COMBINE_SUB) begin
         pr = -pr;
         pi = -pi;
      end
      run_re = saturate(run_re + pr);
      run_im = saturate(run_im + pi);
      if (t.last) begin
         s.re = run_re[ACC_W-1:0];
         s.im = run_im[ACC_W-1:0];
         s.saturated = run_saturated;
         sum_queue.push_back(s);
      end
      run_open = !t.last;
   endfunction

   function automatic logic [SAMPLE_W-1:0] random_sample();
      case ($urandom_range(7))
         0: return S_MAX;
         1: return S_MIN;
         default: return SAMPLE_W'($urandom);
      endcase
   endfunction

   function automatic logic [ACC_W-1:0] random_start();
      logic [63:0] r;
      r = {$urandom, $urandom};
      case ($urandom_range(4))
         0: return r[ACC_W-1:0];
         1: return START_MAX - r[31:0];
         2: return START_MIN + r[31:0];
         3: return r[0] ? START_MAX : START_MIN;
         default: return {{(ACC_W - 32){r[31]}}, r[31:0]};
      endcase
   endfunction

   task automatic push_term(input logic [SAMPLE_W-1:0] mr, input logic [SAMPLE_W-1:0] mi,
                            input logic [SAMPLE_W-1:0] vr, input logic [SAMPLE_W-1:0] vi,
                            input logic [ACC_W-1:0] sr, input logic [ACC_W-1:0] si,
                            input logic last);
      term_type t;
      t.mat_re = mr;
      t.mat_im = mi;
      t.vec_re = vr;
      t.vec_im = vi;
      t.start_re = sr;
      t.start_im = si;
      t.last = last;
      term_queue.push_back(t);
      terms_queued++;
   endtask

   task automatic settle();
      while (terms_sent != terms_queued || sum_queue.size() != 0)
         @(negedge clock);
   endtask

   task automatic write_reg(input logic addr, input logic [1:0] data);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= addr;
      csr_wdata <= data;
      if (addr == REG_CONJUGATE)
         conj_cfg = data[0];
      else
         mode_cfg = data;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic end_phase();
      settle();
      repeat (8) @(negedge clock);
   endtask

   task automatic random_phase(input int n_terms, input bit hold);
      int count, len, i;
      count = 0;
      while (count < n_terms) begin
         len = ($urandom_range(9) == 0) ? $urandom_range(24, 10) : $urandom_range(6, 1);
         for (i = 0; i < len; i++) begin
            if (hold && count == n_terms / 2)
               settle();
            push_term(random_sample(), random_sample(), random_sample(), random_sample(),
                      random_start(), random_start(), i == len - 1);
            count++;
         end
      end
   endtask

   always @(negedge clock) begin
      rsp_tready <= steady || ($urandom_range(99) >= 28);
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_taken) begin
         if (term_queue.size() > 0 && (steady || $urandom_range(99) >= 28)) begin
            req_item = term_queue.pop_front();
            req_tvalid <= 1'b1;
            req_tdata  <= {req_item.start_im, req_item.start_re, req_item.vec_im,
                           req_item.vec_re, req_item.mat_im, req_item.mat_re};
            req_tlast  <= req_item.last;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      sum_type s;
      req_taken <= req_tvalid && req_tready;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            terms_sent++;
            accumulate_term(req_item);
         end
         if (rsp_tvalid && rsp_tready) begin
            if (sum_queue.size() == 0) begin
               $error("unexpected rsp transaction: sum_re %h, sum_im %h",
                      rsp_tdata[ACC_W-1:0], rsp_tdata[2*ACC_W-1:ACC_W]);
               fail_count++;
            end else begin
               s = sum_queue.pop_front();
               if (rsp_tdata[ACC_W-1:0] !== s.re) begin
                  $error("sum_re: expected %h, actual %h", s.re, rsp_tdata[ACC_W-1:0]);
                  fail_count++;
               end
               if (rsp_tdata[2*ACC_W-1:ACC_W] !== s.im) begin
                  $error("sum_im: expected %h, actual %h", s.im,
                         rsp_tdata[2*ACC_W-1:ACC_W]);
                  fail_count++;
               end
               if (rsp_tuser !== s.saturated) begin
                  $error("saturated: expected %b, actual %b", s.saturated, rsp_tuser);
                  fail_count++;
               end
            end
         end
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("status: fail");
            $finish;
         end
      end
   end

   initial begin
      int p;
      repeat (11) @(negedge clock);
      reset <= 1'b0;

      // Start from zero: extreme samples and a start value that must be ignored.
      write_reg(REG_CONJUGATE, 1'b0);
      write_reg(REG_COMBINE, COMBINE_ZERO);
      push_term(S_MIN, S_MIN, S_MIN, S_MIN, START_MAX, START_MIN, 1'b1);
      push_term(S_MAX, S_MIN, S_MIN, S_MAX, START_MIN, START_MAX, 1'b0);
      push_term(S_MAX, S_MAX, S_MAX, S_MAX, START_MAX, START_MAX, 1'b0);
      push_term(16'sd0, 16'sd0, 16'sd0, 16'sd0, START_MIN, START_MIN, 1'b1);
      end_phase();

      // Conjugated matrix with start values at the limits, so both parts saturate.
      write_reg(REG_CONJUGATE, 1'b1);
      write_reg(REG_COMBINE, COMBINE_ADD);
      push_term(S_MAX, S_MAX, S_MAX, 16'sd0, START_MAX, START_MIN, 1'b1);
      push_term(S_MAX, 16'sd0, S_MAX, 16'sd0, START_MAX, 48'd0, 1'b0);
      push_term(S_MIN, 16'sd0, S_MAX, 16'sd0, START_MIN, START_MIN, 1'b1);
      push_term(16'sd1, 16'sd0, 16'sd1, 16'sd0, 48'd100, -48'sd100, 1'b1);
      end_phase();

      write_reg(REG_CONJUGATE, 1'b0);
      write_reg(REG_COMBINE, COMBINE_SUB);
      push_term(S_MAX, S_MIN, S_MAX, 16'sd0, START_MIN, START_MAX, 1'b1);
      push_term(S_MIN, S_MAX, S_MAX, S_MIN, 48'h123456789abc, 48'hedcba9876543, 1'b0);
      push_term(-16'sd1, 16'sd1, S_MIN, S_MIN, START_MAX, START_MAX, 1'b1);
      end_phase();

      // The unused combine code starts from zero.
      write_reg(REG_CONJUGATE, 1'b1);
      write_reg(REG_COMBINE, COMBINE_UNUSED);
      push_term(S_MIN, S_MIN, S_MAX, S_MIN, START_MAX, START_MAX, 1'b0);
      push_term(-16'sd1, 16'sd1, 16'sd1, -16'sd1, START_MIN, START_MIN, 1'b1);
      end_phase();

      for (p = 0; p < 6; p++) begin
         write_reg(REG_CONJUGATE, 2'($urandom_range(1)));
         write_reg(REG_COMBINE, combine_seq[p]);
         steady = (p == 3);
         random_phase(65, p == 1);
         end_phase();
      end

      repeat (10) @(negedge clock);
      if (fail_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
